// ===== rtl/u8d_pkg.sv =====
// Shared types, status codes and a length helper for the UTF-8 stream decoder.
package u8d_pkg;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_TRUNC  = 2'd2;
    localparam logic [1:0] ST_LONG   = 2'd3;

    localparam logic [20:0] CP_MAX   = 21'h10FFFF;

    typedef struct packed {
        logic        pre_v;
        logic [2:0]  pre_cnt;
        logic        main_v;
        logic [20:0] cp;
        logic [2:0]  cnt;
        logic [1:0]  st;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [2:0] needed_len(input logic [20:0] v);
        logic [2:0] len;
        len = 3'd0;
        if (v inside {[21'h000000:21'h00007F]}) begin
            len = 3'd1;
        end else if (v inside {[21'h000080:21'h0007FF]}) begin
            len = 3'd2;
        end else if (v inside {[21'h000800:21'h00FFFF]}) begin
            len = 3'd3;
        end else if (v inside {[21'h010000:CP_MAX]}) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

// ===== rtl/u8d_front.sv =====
// Front end: accepts bytes, tracks the open sequence and builds result entries.
module u8d_front import u8d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_stream,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [1:0]  r_rem, n_rem;
    logic [2:0]  r_len, n_len;
    logic [20:0] r_acc, n_acc;
    logic [20:0] acc_sh;
    logic [1:0]  rem_dec;
    logic        do_fresh;
    logic        accept;
    t_entry      ent;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign acc_sh  = {r_acc[14:0], i_in_byte[5:0]};
    assign rem_dec = r_rem - 2'd1;

    always_comb begin
        n_rem    = r_rem;
        n_len    = r_len;
        n_acc    = r_acc;
        ent      = '0;
        do_fresh = 1'b0;
        if (r_rem != 2'd0) begin
            if (i_in_byte[7:6] == 2'b10) begin
                n_acc = acc_sh;
                n_rem = rem_dec;
                if (rem_dec == 2'd0) begin
                    ent.main_v = 1'b1;
                    ent.cnt    = r_len;
                    if (needed_len(acc_sh) != r_len) begin
                        ent.st = ST_LONG;
                    end else begin
                        ent.st = ST_OK;
                        ent.cp = acc_sh;
                    end
                    n_rem = 2'd0;
                    n_len = 3'd0;
                    n_acc = '0;
                end else if (i_end_of_stream) begin
                    ent.main_v = 1'b1;
                    ent.st     = ST_TRUNC;
                    ent.cnt    = r_len - {1'b0, rem_dec};
                    n_rem = 2'd0;
                    n_len = 3'd0;
                    n_acc = '0;
                end
            end else begin
                ent.pre_v   = 1'b1;
                ent.pre_cnt = r_len - {1'b0, r_rem};
                n_rem    = 2'd0;
                n_len    = 3'd0;
                n_acc    = '0;
                do_fresh = 1'b1;
            end
        end else begin
            do_fresh = 1'b1;
        end

        if (do_fresh) begin
            if (i_in_byte inside {[8'h00:8'h7F]}) begin
                ent.main_v = 1'b1;
                ent.cp     = {14'd0, i_in_byte[6:0]};
                ent.cnt    = 3'd1;
                ent.st     = ST_OK;
            end else if (i_in_byte inside {[8'hC0:8'hF7]}) begin
                if (i_end_of_stream) begin
                    ent.main_v = 1'b1;
                    ent.cnt    = 3'd1;
                    ent.st     = ST_TRUNC;
                end else if (i_in_byte inside {[8'hC0:8'hDF]}) begin
                    n_len = 3'd2;
                    n_rem = 2'd1;
                    n_acc = {16'd0, i_in_byte[4:0]};
                end else if (i_in_byte inside {[8'hE0:8'hEF]}) begin
                    n_len = 3'd3;
                    n_rem = 2'd2;
                    n_acc = {17'd0, i_in_byte[3:0]};
                end else begin
                    n_len = 3'd4;
                    n_rem = 2'd3;
                    n_acc = {18'd0, i_in_byte[2:0]};
                end
            end else begin
                ent.main_v = 1'b1;
                ent.cp     = {13'd0, i_in_byte};
                ent.cnt    = 3'd1;
                ent.st     = ST_BAD;
            end
        end
    end

    assign o_entry = ent;
    assign o_push  = accept && (ent.pre_v || ent.main_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
            r_len <= 3'd0;
            r_acc <= '0;
        end else if (accept) begin
            r_rem <= n_rem;
            r_len <= n_len;
            r_acc <= n_acc;
        end
    end

endmodule

// ===== rtl/u8d_fifo.sv =====
// Short register queue of result entries between front and back end.
module u8d_fifo import u8d_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [IDX_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + IDX_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + IDX_W'(1);
            end
        end
    end

endmodule

// ===== rtl/u8d_back.sv =====
// Back end: splits each entry into one or two results and drives the output register.
module u8d_back import u8d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_byte_count,
    output logic [1:0]  o_status,
    output logic        o_last_of_run
);

    logic        r_valid, n_valid;
    logic        r_phase, n_phase;
    logic [20:0] r_cp, n_cp;
    logic [2:0]  r_cnt, n_cnt;
    logic [1:0]  r_st, n_st;
    logic        r_last, n_last;
    logic        advance;
    logic        pop;

    assign advance = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid && !i_ready;
        n_phase = r_phase;
        n_cp    = r_cp;
        n_cnt   = r_cnt;
        n_st    = r_st;
        n_last  = r_last;
        pop     = 1'b0;
        if (advance && !i_q_status.empty) begin
            n_valid = 1'b1;
            if (i_head.pre_v && !r_phase) begin
                n_cp   = '0;
                n_cnt  = i_head.pre_cnt;
                n_st   = ST_TRUNC;
                n_last = !i_head.main_v;
                if (i_head.main_v) begin
                    n_phase = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                n_cp    = i_head.cp;
                n_cnt   = i_head.cnt;
                n_st    = i_head.st;
                n_last  = 1'b1;
                n_phase = 1'b0;
                pop     = 1'b1;
            end
        end
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp   <= n_cp;
        r_cnt  <= n_cnt;
        r_st   <= n_st;
        r_last <= n_last;
    end

    assign o_valid       = r_valid;
    assign o_code_point  = r_cp;
    assign o_byte_count  = r_cnt;
    assign o_status      = r_st;
    assign o_last_of_run = r_last;

endmodule

// ===== rtl/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder: front end, entry queue, back end.
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_ready  i_in_byte, i_end_of_stream
//  result    out        o_valid / i_ready  o_code_point, o_byte_count, o_status,
//                                          o_last_of_run
//
// One byte is accepted per cycle while the entry queue has room; a result
// passes the entry queue, then the back-end output register. A byte that
// yields two results holds the queue head until both have left. Results
// leave at one per cycle while i_ready is high. Synchronous reset idles the
// decoder and empties the queue. A stalled output fills it, then drops o_ready.
module utf8_stream_decoder_top import u8d_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_byte_count,
    output logic [1:0]  o_status,
    output logic        o_last_of_run
);

    t_entry    push_entry;
    t_entry    head_entry;
    t_q_status q_status;
    logic      push;
    logic      pop;

    u8d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    u8d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_entry),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code_point  (o_code_point),
        .o_byte_count  (o_byte_count),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("entry pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("entry popped from an empty queue");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_code_point <= CP_MAX))
        else $error("ok result above the code point range");

    a_err_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_TRUNC || o_status == ST_LONG)) |->
        (o_code_point == 21'd0))
        else $error("error result carries a nonzero code point");

endmodule

// ===== verif/utf8_stream_decoder_tb.sv =====
// Self-checking testbench for utf8_stream_decoder_top: random UTF-8 byte streams under backpressure.
`timescale 1ns / 1ps

module testbench import u8d_pkg::*;;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 175;

    typedef struct {
        bit [20:0] cp;
        bit [2:0]  cnt;
        bit [1:0]  st;
        bit        last;
    } t_decoded_char;

    class t_char_tracker;
        t_decoded_char expected_chars[$];
        t_decoded_char step_out[$];
        bit [1:0]      cont_left;
        bit [2:0]      lead_len;
        bit [20:0]     acc;
        int            errors;
        int            checked;
        int            status_seen[4];

        function void clear_sequence();
            cont_left = 2'd0;
            lead_len  = 3'd0;
            acc       = 21'd0;
        endfunction

        function bit [2:0] shortest_len(bit [20:0] v);
            if (v <= 21'h00007F) return 3'd1;
            if (v <= 21'h0007FF) return 3'd2;
            if (v <= 21'h00FFFF) return 3'd3;
            if (v <= 21'h10FFFF) return 3'd4;
            return 3'd0;
        endfunction

        function void push_char(bit [20:0] cp, bit [2:0] cnt, bit [1:0] st);
            t_decoded_char c;
            c.cp   = cp;
            c.cnt  = cnt;
            c.st   = st;
            c.last = 1'b0;
            step_out.push_back(c);
        endfunction

        function void start_fresh(bit [7:0] b, bit eos);
            bit [2:0]  len;
            bit [20:0] lead_bits;
            if (!b[7]) begin
                push_char({14'd0, b[6:0]}, 3'd1, ST_OK);
                return;
            end
            if (b[7:5] == 3'b110) begin
                len = 3'd2;
                lead_bits = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                len = 3'd3;
                lead_bits = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                len = 3'd4;
                lead_bits = {18'd0, b[2:0]};
            end else begin
                push_char({13'd0, b}, 3'd1, ST_BAD);
                return;
            end
            if (eos) begin
                clear_sequence();
                push_char(21'd0, 3'd1, ST_TRUNC);
            end else begin
                lead_len  = len;
                cont_left = 2'(len - 3'd1);
                acc       = lead_bits;
            end
        endfunction

        function void note_byte(bit [7:0] b, bit eos);
            t_decoded_char c;
            step_out.delete();
            if (cont_left != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    acc = {acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        if (shortest_len(acc) != lead_len) begin
                            push_char(21'd0, lead_len, ST_LONG);
                        end else begin
                            push_char(acc, lead_len, ST_OK);
                        end
                        clear_sequence();
                    end else if (eos) begin
                        push_char(21'd0, lead_len - cont_left, ST_TRUNC);
                        clear_sequence();
                    end
                end else begin
                    push_char(21'd0, lead_len - cont_left, ST_TRUNC);
                    clear_sequence();
                    start_fresh(b, eos);
                end
            end else begin
                start_fresh(b, eos);
            end
            foreach (step_out[i]) begin
                c = step_out[i];
                c.last = (i == step_out.size() - 1);
                expected_chars.push_back(c);
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_char(bit [20:0] cp, bit [2:0] cnt, bit [1:0] st, bit last);
            t_decoded_char e;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected result cp=%h cnt=%0d st=%0d last=%0b",
                                 cp, cnt, st, last));
                return;
            end
            e = expected_chars.pop_front();
            checked++;
            status_seen[st]++;
            if (cp != e.cp) report($sformatf("code_point got %h want %h", cp, e.cp));
            if (cnt != e.cnt) report($sformatf("byte_count got %0d want %0d", cnt, e.cnt));
            if (st != e.st) report($sformatf("status got %0d want %0d", st, e.st));
            if (last != e.last) report($sformatf("last_of_run got %0b want %0b", last, e.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_in_byte;
    logic        i_end_of_stream;
    logic        o_valid;
    logic        i_ready;
    logic [20:0] o_code_point;
    logic [2:0]  o_byte_count;
    logic [1:0]  o_status;
    logic        o_last_of_run;

    t_char_tracker tracker;
    int idle_pct  = 0;
    int stall_pct = 0;
    int bytes_sent;
    int cycles;

    int sender_idle[4]    = '{0, 87, 0, 33};
    int receiver_stall[4] = '{0, 0, 87, 33};

    bit [8:0] directed_bytes[24] = '{
        9'h000, 9'h07F, 9'h0C0, 9'h080, 9'h0DF, 9'h0BF, 9'h0ED, 9'h0A0,
        9'h080, 9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h0F4, 9'h090, 9'h080,
        9'h080, 9'h080, 9'h0FF, 9'h0E2, 9'h041, 9'h1C3, 9'h0E2, 9'h182
    };

    utf8_stream_decoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_code_point    (o_code_point),
        .o_byte_count    (o_byte_count),
        .o_status        (o_status),
        .o_last_of_run   (o_last_of_run)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("utf8_stream_decoder_top verification failed");
            $finish;
        end
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            tracker.check_char(o_code_point, o_byte_count, o_status, o_last_of_run);
        end
    end

    // Call at a falling edge; returns at the falling edge after the request is taken.
    task automatic send(input bit [7:0] b, input bit eos);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid         = 1'b1;
        i_in_byte       = b;
        i_end_of_stream = eos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_byte(b, eos);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_wellformed(input bit eos_end);
        int        len;
        bit [20:0] cp;
        bit [7:0]  seq_bytes[4];
        len = $urandom_range(4, 1);
        case (len)
            1: begin
                cp = 21'($urandom_range(21'h7F, 0));
                seq_bytes[0] = {1'b0, cp[6:0]};
            end
            2: begin
                cp = 21'($urandom_range(21'h7FF, 21'h80));
                seq_bytes[0] = {3'b110, cp[10:6]};
                seq_bytes[1] = {2'b10, cp[5:0]};
            end
            3: begin
                cp = 21'($urandom_range(21'hFFFF, 21'h800));
                seq_bytes[0] = {4'b1110, cp[15:12]};
                seq_bytes[1] = {2'b10, cp[11:6]};
                seq_bytes[2] = {2'b10, cp[5:0]};
            end
            default: begin
                cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
                seq_bytes[0] = {5'b11110, cp[20:18]};
                seq_bytes[1] = {2'b10, cp[17:12]};
                seq_bytes[2] = {2'b10, cp[11:6]};
                seq_bytes[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < len; i++) begin
            send(seq_bytes[i], eos_end && (i == len - 1));
        end
    endtask

    task automatic send_random_unit();
        int       pick;
        int       len;
        int       keep;
        bit       cut;
        bit [7:0] lead;
        pick = $urandom_range(99);
        lead = 8'($urandom_range(8'hF7, 8'hC0));
        len  = lead[5] ? (lead[4] ? 4 : 3) : 2;
        if (pick < 60) begin
            send_wellformed($urandom_range(19) == 0);
        end else if (pick < 75) begin
            send(lead, 1'b0);
            for (int i = 1; i < len; i++) begin
                send(8'h80 | 8'($urandom_range(63)),
                     (i == len - 1) && ($urandom_range(19) == 0));
            end
        end else if (pick < 85) begin
            keep = $urandom_range(len - 2, 0);
            cut  = 1'($urandom_range(1));
            send(lead, cut && (keep == 0));
            for (int i = 0; i < keep; i++) begin
                send(8'h80 | 8'($urandom_range(63)), cut && (i == keep - 1));
            end
        end else begin
            send(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
    endtask

    initial begin
        int target;
        tracker         = new();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_in_byte       = 8'd0;
        i_end_of_stream = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_bytes[i]) send(directed_bytes[i][7:0], directed_bytes[i][8]);

        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = sender_idle[phase];
            stall_pct = receiver_stall[phase];
            target    = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_random_unit();
        end
        i_valid = 1'b0;

        while (tracker.expected_chars.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("decoded %0d bytes into %0d checked results over four backpressure phases",
                 bytes_sent, tracker.checked);
        $display("results by status ok/invalid/truncated/overlong: %0d/%0d/%0d/%0d",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_BAD],
                 tracker.status_seen[ST_TRUNC], tracker.status_seen[ST_LONG]);
        if (tracker.errors == 0 && tracker.expected_chars.size() == 0) begin
            $display("utf8_stream_decoder_top verification clean");
        end else begin
            $display("utf8_stream_decoder_top verification failed");
        end
        $finish;
    end

endmodule

// ===== utf8_stream_decoder_top.f =====
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_fifo.sv
rtl/u8d_back.sv
rtl/utf8_stream_decoder_top.sv
verif/utf8_stream_decoder_tb.sv
